// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/sdc_pkg.sv
package sdc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int AXES       = 3;
    localparam int LANES      = 2 * AXES;
    localparam int POS_W      = 32;
    localparam int MASS_W     = 24;
    localparam int DELTA_W    = POS_W + 1;
    localparam int SQ_W       = 2 * DELTA_W;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int SQRT_REM_W = ROOT_W + 4;
    localparam int SUM_W      = MASS_W + 1;
    localparam int DEN_W      = ROOT_W + SUM_W;
    localparam int PROD_W     = DELTA_W + MASS_W;
    localparam int ERR_W      = ROOT_W;
    localparam int NUM_W      = PROD_W + ERR_W;
    localparam int QUO_W      = ERR_W;
    localparam int SPLIT_W    = 29;

    localparam logic [POS_W-1:0] REST_RESET = POS_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic signed [POS_W-1:0]  a_x;
        logic signed [POS_W-1:0]  a_y;
        logic signed [POS_W-1:0]  a_z;
        logic signed [POS_W-1:0]  b_x;
        logic signed [POS_W-1:0]  b_y;
        logic signed [POS_W-1:0]  b_z;
        logic [MASS_W-1:0]        inv_mass_a;
        logic [MASS_W-1:0]        inv_mass_b;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  new_a_x;
        logic signed [POS_W-1:0]  new_a_y;
        logic signed [POS_W-1:0]  new_a_z;
        logic signed [POS_W-1:0]  new_b_x;
        logic signed [POS_W-1:0]  new_b_y;
        logic signed [POS_W-1:0]  new_b_z;
        logic                     degenerate;
    } out_item_t;

    // Original positions and delta signs, carried to the end of the pipeline.
    typedef struct packed {
        logic [AXES-1:0][POS_W-1:0] a;
        logic [AXES-1:0][POS_W-1:0] b;
        logic [AXES-1:0]            dneg;
    } pos_ctx_t;

    typedef struct packed {
        pos_ctx_t                     pos;
        logic [AXES-1:0][DELTA_W-1:0] ad;
        logic [MASS_W-1:0]            ia;
        logic [MASS_W-1:0]            ib;
        logic [SQ_W-1:0]              len2;
    } sq_item_t;

    typedef struct packed {
        pos_ctx_t                     pos;
        logic [AXES-1:0][DELTA_W-1:0] ad;
        logic [MASS_W-1:0]            ia;
        logic [MASS_W-1:0]            ib;
        logic [ROOT_W-1:0]            len;
    } len_item_t;

    // Lanes 0..2 correct A, lanes 3..5 correct B.
    typedef struct packed {
        pos_ctx_t                    pos;
        logic                        eneg;
        logic                        degen;
        logic [DEN_W-1:0]            den;
        logic [LANES-1:0][NUM_W-1:0] num;
    } div_item_t;

    typedef struct packed {
        pos_ctx_t                    pos;
        logic                        eneg;
        logic                        degen;
        logic [LANES-1:0][QUO_W-1:0] quo;
    } quo_item_t;

endpackage

// File: hdl/sdc_front.sv
module sdc_front import sdc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  in_item_t in_item,
    output logic     out_valid,
    output sq_item_t out_item
);

    logic [AXES-1:0][POS_W-1:0]   a_in;
    logic [AXES-1:0][POS_W-1:0]   b_in;
    logic [AXES-1:0]              dneg_next;
    logic [AXES-1:0][DELTA_W-1:0] ad_next;

    logic                         st1_valid_reg;
    pos_ctx_t                     st1_pos_reg;
    logic [AXES-1:0][DELTA_W-1:0] st1_ad_reg;
    logic [MASS_W-1:0]            st1_ia_reg;
    logic [MASS_W-1:0]            st1_ib_reg;

    logic                         st2_valid_reg;
    pos_ctx_t                     st2_pos_reg;
    logic [AXES-1:0][DELTA_W-1:0] st2_ad_reg;
    logic [MASS_W-1:0]            st2_ia_reg;
    logic [MASS_W-1:0]            st2_ib_reg;
    logic [AXES-1:0][SQ_W-1:0]    st2_sq_reg;

    logic                         out_valid_reg;
    sq_item_t                     out_item_reg;

    assign a_in = {in_item.a_z, in_item.a_y, in_item.a_x};
    assign b_in = {in_item.b_z, in_item.b_y, in_item.b_x};

    always_comb begin
        logic [DELTA_W-1:0] delta;
        delta = '0;
        for (int k = 0; k < AXES; k++) begin
            delta = {b_in[k][POS_W-1], b_in[k]} - {a_in[k][POS_W-1], a_in[k]};
            dneg_next[k] = delta[DELTA_W-1];
            ad_next[k] = delta[DELTA_W-1] ? (~delta + 1'b1) : delta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            st1_valid_reg <= in_valid;
            st2_valid_reg <= st1_valid_reg;
            out_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_pos_reg.a    <= a_in;
            st1_pos_reg.b    <= b_in;
            st1_pos_reg.dneg <= dneg_next;
            st1_ad_reg       <= ad_next;
            st1_ia_reg       <= in_item.inv_mass_a;
            st1_ib_reg       <= in_item.inv_mass_b;

            st2_pos_reg <= st1_pos_reg;
            st2_ad_reg  <= st1_ad_reg;
            st2_ia_reg  <= st1_ia_reg;
            st2_ib_reg  <= st1_ib_reg;
            for (int k = 0; k < AXES; k++) begin
                st2_sq_reg[k] <= SQ_W'(st1_ad_reg[k]) * SQ_W'(st1_ad_reg[k]);
            end

            out_item_reg.pos  <= st2_pos_reg;
            out_item_reg.ad   <= st2_ad_reg;
            out_item_reg.ia   <= st2_ia_reg;
            out_item_reg.ib   <= st2_ib_reg;
            out_item_reg.len2 <= st2_sq_reg[0] + st2_sq_reg[1] + st2_sq_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: hdl/sdc_sqrt.sv
`include "assert_macros.svh"

module sdc_sqrt import sdc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  sq_item_t  in_item,
    output logic      out_valid,
    output len_item_t out_item
);

    typedef struct packed {
        pos_ctx_t                     pos;
        logic [AXES-1:0][DELTA_W-1:0] ad;
        logic [MASS_W-1:0]            ia;
        logic [MASS_W-1:0]            ib;
        logic [SQ_W-1:0]              bits;
        logic [SQRT_REM_W-1:0]        rem;
        logic [ROOT_W-1:0]            root;
    } sqrt_stage_t;

    // One root bit per stage, taking two radicand bits at a time.
    function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t cur);
        sqrt_stage_t           nxt;
        logic [SQRT_REM_W-1:0] rem2;
        logic [SQRT_REM_W-1:0] trial;
        nxt   = cur;
        rem2  = {cur.rem[SQRT_REM_W-3:0], cur.bits[SQ_W-1 -: 2]};
        trial = SQRT_REM_W'({cur.root, 2'b01});
        if (rem2 >= trial) begin
            nxt.rem  = rem2 - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = rem2;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        nxt.bits = {cur.bits[SQ_W-3:0], 2'b00};
        return nxt;
    endfunction

    sqrt_stage_t           first;
    sqrt_stage_t           stage_next [ROOT_W];
    sqrt_stage_t           stage_reg  [ROOT_W];
    logic [ROOT_W-1:0]     valid_reg;
    logic [SQRT_REM_W-1:0] last_rem;
    logic [SQRT_REM_W-1:0] last_bound;

    always_comb begin
        first.pos  = in_item.pos;
        first.ad   = in_item.ad;
        first.ia   = in_item.ia;
        first.ib   = in_item.ib;
        first.bits = in_item.len2;
        first.rem  = '0;
        first.root = '0;
        stage_next[0] = sqrt_step(first);
        for (int i = 1; i < ROOT_W; i++) begin
            stage_next[i] = sqrt_step(stage_reg[i-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < ROOT_W; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid     = valid_reg[ROOT_W-1];
    assign out_item.pos  = stage_reg[ROOT_W-1].pos;
    assign out_item.ad   = stage_reg[ROOT_W-1].ad;
    assign out_item.ia   = stage_reg[ROOT_W-1].ia;
    assign out_item.ib   = stage_reg[ROOT_W-1].ib;
    assign out_item.len  = stage_reg[ROOT_W-1].root;

    // A floor square root leaves a remainder of at most twice the root.
    assign last_rem   = stage_reg[ROOT_W-1].rem;
    assign last_bound = SQRT_REM_W'({stage_reg[ROOT_W-1].root, 1'b0});

    `ASSERT_IMPLIES(a_sqrt_rem_bound, aclk, aresetn, out_valid, last_rem <= last_bound)

endmodule

// File: hdl/sdc_mid.sv
module sdc_mid import sdc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [POS_W-1:0] rest_distance,
    input  logic             in_valid,
    input  len_item_t        in_item,
    output logic             out_valid,
    output div_item_t        out_item
);

    localparam int LO_W = SPLIT_W + ERR_W;
    localparam int HI_W = PROD_W - SPLIT_W + ERR_W;

    logic [SUM_W-1:0]             mass_sum;
    logic [ERR_W:0]               err;
    logic [ERR_W:0]               err_mag;

    logic                         m1_valid_reg;
    pos_ctx_t                     m1_pos_reg;
    logic                         m1_eneg_reg;
    logic                         m1_degen_reg;
    logic [ERR_W-1:0]             m1_ae_reg;
    logic [DEN_W-1:0]             m1_den_reg;
    logic [LANES-1:0][PROD_W-1:0] m1_prod_reg;

    logic                         m2_valid_reg;
    pos_ctx_t                     m2_pos_reg;
    logic                         m2_eneg_reg;
    logic                         m2_degen_reg;
    logic [DEN_W-1:0]             m2_den_reg;
    logic [LANES-1:0][LO_W-1:0]   m2_lo_reg;
    logic [LANES-1:0][HI_W-1:0]   m2_hi_reg;

    logic                         out_valid_reg;
    div_item_t                    out_item_reg;

    assign mass_sum = SUM_W'(in_item.ia) + SUM_W'(in_item.ib);
    assign err      = {1'b0, in_item.len} - {2'b00, rest_distance};
    assign err_mag  = err[ERR_W] ? (~err + 1'b1) : err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg  <= in_valid;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_pos_reg   <= in_item.pos;
            m1_eneg_reg  <= err[ERR_W];
            m1_degen_reg <= (in_item.len == '0) || (mass_sum == '0);
            m1_ae_reg    <= err_mag[ERR_W-1:0];
            m1_den_reg   <= DEN_W'(in_item.len) * DEN_W'(mass_sum);
            for (int k = 0; k < AXES; k++) begin
                m1_prod_reg[k]        <= PROD_W'(in_item.ad[k]) * PROD_W'(in_item.ia);
                m1_prod_reg[AXES + k] <= PROD_W'(in_item.ad[k]) * PROD_W'(in_item.ib);
            end

            // The wide product is split in two partial products.
            m2_pos_reg   <= m1_pos_reg;
            m2_eneg_reg  <= m1_eneg_reg;
            m2_degen_reg <= m1_degen_reg;
            m2_den_reg   <= m1_den_reg;
            for (int j = 0; j < LANES; j++) begin
                m2_lo_reg[j] <= LO_W'(m1_prod_reg[j][SPLIT_W-1:0]) * LO_W'(m1_ae_reg);
                m2_hi_reg[j] <= HI_W'(m1_prod_reg[j][PROD_W-1:SPLIT_W]) * HI_W'(m1_ae_reg);
            end

            out_item_reg.pos   <= m2_pos_reg;
            out_item_reg.eneg  <= m2_eneg_reg;
            out_item_reg.degen <= m2_degen_reg;
            out_item_reg.den   <= m2_den_reg;
            for (int j = 0; j < LANES; j++) begin
                out_item_reg.num[j] <= NUM_W'(m2_lo_reg[j])
                                     + (NUM_W'(m2_hi_reg[j]) << SPLIT_W);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: hdl/sdc_div.sv
`include "assert_macros.svh"

module sdc_div import sdc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  div_item_t in_item,
    output logic      out_valid,
    output quo_item_t out_item
);

    typedef struct packed {
        pos_ctx_t                    pos;
        logic                        eneg;
        logic                        degen;
        logic [DEN_W-1:0]            den;
        logic [LANES-1:0][DEN_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] low;
        logic [LANES-1:0][QUO_W-1:0] quo;
    } div_stage_t;

    // One quotient bit per stage in every lane; all lanes share the divisor.
    function automatic div_stage_t div_step(input div_stage_t cur);
        div_stage_t     nxt;
        logic [DEN_W:0] rem2;
        nxt = cur;
        for (int j = 0; j < LANES; j++) begin
            rem2 = {cur.rem[j], cur.low[j][QUO_W-1]};
            if (rem2 >= {1'b0, cur.den}) begin
                nxt.rem[j] = DEN_W'(rem2 - {1'b0, cur.den});
                nxt.quo[j] = {cur.quo[j][QUO_W-2:0], 1'b1};
            end else begin
                nxt.rem[j] = rem2[DEN_W-1:0];
                nxt.quo[j] = {cur.quo[j][QUO_W-2:0], 1'b0};
            end
            nxt.low[j] = {cur.low[j][QUO_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    div_stage_t       first;
    div_stage_t       stage_next [QUO_W];
    div_stage_t       stage_reg  [QUO_W];
    logic [QUO_W-1:0] valid_reg;
    logic [DEN_W-1:0] last_den;
    logic [DEN_W-1:0] last_rem_a;
    logic [DEN_W-1:0] last_rem_b;
    logic             last_live;

    // The quotient is known to fit in QUO_W bits, so the upper numerator
    // bits already form a partial remainder below the divisor.
    always_comb begin
        first.pos   = in_item.pos;
        first.eneg  = in_item.eneg;
        first.degen = in_item.degen;
        first.den   = in_item.den;
        for (int j = 0; j < LANES; j++) begin
            first.rem[j] = DEN_W'(in_item.num[j][NUM_W-1:QUO_W]);
            first.low[j] = in_item.num[j][QUO_W-1:0];
            first.quo[j] = '0;
        end
        stage_next[0] = div_step(first);
        for (int i = 1; i < QUO_W; i++) begin
            stage_next[i] = div_step(stage_reg[i-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[QUO_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < QUO_W; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid      = valid_reg[QUO_W-1];
    assign out_item.pos   = stage_reg[QUO_W-1].pos;
    assign out_item.eneg  = stage_reg[QUO_W-1].eneg;
    assign out_item.degen = stage_reg[QUO_W-1].degen;
    assign out_item.quo   = stage_reg[QUO_W-1].quo;

    assign last_den   = stage_reg[QUO_W-1].den;
    assign last_rem_a = stage_reg[QUO_W-1].rem[0];
    assign last_rem_b = stage_reg[QUO_W-1].rem[AXES];
    assign last_live  = out_valid && !stage_reg[QUO_W-1].degen;

    `ASSERT_IMPLIES(a_div_rem_a, aclk, aresetn, last_live, last_rem_a < last_den)
    `ASSERT_IMPLIES(a_div_rem_b, aclk, aresetn, last_live, last_rem_b < last_den)

endmodule

// File: hdl/spring_distance_constraint.sv
// Items pass the front, square-root, mid and divider stages and an output register.
// Throughput: one item per cycle while the output is not stalled; the square root
// and the six correction dividers each produce one bit per pipeline stage, which
// sets the depth. A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (aresetn low, synchronous) empties the pipeline and sets rest_distance to 1.0.
module spring_distance_constraint import sdc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item,
    input  logic             cfg_wr_en,
    input  logic [POS_W-1:0] cfg_wr_data
);

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Adds a signed correction of magnitude quo and saturates to the position range.
    function automatic logic [POS_W-1:0] apply_corr(input logic [POS_W-1:0] pos,
                                                    input logic [QUO_W-1:0] quo,
                                                    input logic             neg);
        logic [POS_W+2:0] p;
        logic [POS_W+2:0] c;
        logic [POS_W+2:0] s;
        p = {{3{pos[POS_W-1]}}, pos};
        c = {2'b00, quo};
        if (neg) begin
            c = ~c + 1'b1;
        end
        s = p + c;
        if (!s[POS_W+2] && (s[POS_W+1:POS_W-1] != 3'b000)) begin
            return POS_MAX;
        end else if (s[POS_W+2] && (s[POS_W+1:POS_W-1] != 3'b111)) begin
            return POS_MIN;
        end
        return s[POS_W-1:0];
    endfunction

    logic             en;
    logic [POS_W-1:0] rest_distance_reg;

    logic             front_valid;
    sq_item_t         front_item;
    logic             sqrt_valid;
    len_item_t        sqrt_item;
    logic             mid_valid;
    div_item_t        mid_item;
    logic             div_valid;
    quo_item_t        div_item;

    logic [AXES-1:0][POS_W-1:0] new_a;
    logic [AXES-1:0][POS_W-1:0] new_b;
    out_item_t        m_item_next;
    out_item_t        m_item_reg;
    logic             m_valid_reg;

    // Every stage advances together unless a finished item is waiting.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_distance_reg <= REST_RESET;
        end else if (cfg_wr_en) begin
            rest_distance_reg <= cfg_wr_data;
        end
    end

    sdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    sdc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (sqrt_valid),
        .out_item  (sqrt_item)
    );

    sdc_mid u_mid (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .rest_distance (rest_distance_reg),
        .in_valid      (sqrt_valid),
        .in_item       (sqrt_item),
        .out_valid     (mid_valid),
        .out_item      (mid_item)
    );

    sdc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mid_valid),
        .in_item   (mid_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // B moves against A, so its correction takes the opposite sign.
    always_comb begin
        logic neg;
        neg = 1'b0;
        for (int k = 0; k < AXES; k++) begin
            neg = div_item.pos.dneg[k] ^ div_item.eneg;
            if (div_item.degen) begin
                new_a[k] = div_item.pos.a[k];
                new_b[k] = div_item.pos.b[k];
            end else begin
                new_a[k] = apply_corr(div_item.pos.a[k], div_item.quo[k], neg);
                new_b[k] = apply_corr(div_item.pos.b[k], div_item.quo[AXES + k], !neg);
            end
        end
        m_item_next.new_a_x    = new_a[0];
        m_item_next.new_a_y    = new_a[1];
        m_item_next.new_a_z    = new_a[2];
        m_item_next.new_b_x    = new_b[0];
        m_item_next.new_b_y    = new_b[1];
        m_item_next.new_b_z    = new_b[2];
        m_item_next.degenerate = div_item.degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
